@@ hdl/ibmw_pkg.sv @@
// shared constants and types of the indexed block map walker
package ibmw_pkg;

	localparam int DIRECT_SLOTS      = 11;
	localparam int ENTRIES_PER_INDEX = 16;
	localparam int IMAGE_BLOCKS      = 256;
	localparam int ENTRY_W           = $clog2(ENTRIES_PER_INDEX);
	localparam int BLK_W             = $clog2(IMAGE_BLOCKS);
	localparam int STORE_DEPTH       = IMAGE_BLOCKS * ENTRIES_PER_INDEX;
	localparam int STORE_AW          = $clog2(STORE_DEPTH);
	localparam int LIMIT_W           = 9;

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FINAL = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] REG_BLOCK_LIMIT = 2'd0;
	localparam logic [1:0] REG_START_BLOCK = 2'd1;

	typedef struct packed {
		logic             avail;
		logic [BLK_W-1:0] blk;
	} alloc_stat_t;

endpackage

@@ hdl/ibmw_ram.sv @@
// generic single write port ram with registered read
module ibmw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/ibmw_alloc.sv @@
// bump allocator with block limit and start block registers
module ibmw_alloc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [ibmw_pkg::LIMIT_W-1:0]  cfg_data,
	input  logic                          take,
	output ibmw_pkg::alloc_stat_t         stat
);

	localparam logic [ibmw_pkg::LIMIT_W-1:0] MaxBlocks =
		ibmw_pkg::LIMIT_W'(ibmw_pkg::IMAGE_BLOCKS);

	logic [ibmw_pkg::LIMIT_W-1:0] limit_q;
	logic [ibmw_pkg::LIMIT_W-1:0] next_q;
	logic [ibmw_pkg::LIMIT_W-1:0] eff_limit;
	logic [ibmw_pkg::BLK_W-1:0]   start_v;

	assign cfg_ready = 1'b1;
	assign eff_limit = (limit_q > MaxBlocks) ? MaxBlocks : limit_q;
	assign start_v   = cfg_data[ibmw_pkg::BLK_W-1:0];
	assign stat.avail = next_q < eff_limit;
	assign stat.blk   = next_q[ibmw_pkg::BLK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MaxBlocks;
			next_q  <= ibmw_pkg::LIMIT_W'(1);
		end else if (cfg_valid && cfg_ready && cfg_index == ibmw_pkg::REG_BLOCK_LIMIT) begin
			limit_q <= cfg_data;
		end else if (cfg_valid && cfg_ready && cfg_index == ibmw_pkg::REG_START_BLOCK) begin
			next_q <= (start_v == '0) ? ibmw_pkg::LIMIT_W'(1)
			                          : {{(ibmw_pkg::LIMIT_W-ibmw_pkg::BLK_W){1'b0}}, start_v};
		end else if (take) begin
			next_q <= next_q + 1'b1;
		end
	end

endmodule

@@ hdl/ibmw_ctl.sv @@
// walk sequencer: pointer set, index entry walk, block clearing and results
module ibmw_ctl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [15:0]                         file_block,
	input  logic                                new_file,
	input  ibmw_pkg::alloc_stat_t               stat,
	output logic                                take,
	output logic                                ram_we,
	output logic [ibmw_pkg::STORE_AW-1:0]       ram_waddr,
	output logic [ibmw_pkg::BLK_W-1:0]          ram_wdata,
	output logic [ibmw_pkg::STORE_AW-1:0]       ram_raddr,
	input  logic [ibmw_pkg::BLK_W-1:0]          ram_rdata,
	output logic                                strobe,
	output logic [1:0]                          kind,
	output logic [7:0]                          block_number,
	output logic                                in_pointer_set,
	output logic [3:0]                          pointer_slot,
	output logic [7:0]                          parent_block,
	output logic [3:0]                          parent_entry,
	output logic                                last
);

	localparam int EW = ibmw_pkg::ENTRY_W;
	localparam int BW = ibmw_pkg::BLK_W;
	localparam logic [15:0] Ds = 16'(ibmw_pkg::DIRECT_SLOTS);
	localparam logic [15:0] E1 = 16'(ibmw_pkg::ENTRIES_PER_INDEX);
	localparam logic [15:0] E2 = 16'(ibmw_pkg::ENTRIES_PER_INDEX * ibmw_pkg::ENTRIES_PER_INDEX);
	localparam logic [16:0] E3 = 17'(ibmw_pkg::ENTRIES_PER_INDEX * ibmw_pkg::ENTRIES_PER_INDEX
		* ibmw_pkg::ENTRIES_PER_INDEX);

	typedef enum logic [2:0] {S_IDLE, S_DEC, S_PTR, S_CLR, S_RD, S_CHK} state_t;

	state_t          state_q;
	logic [15:0]     idx_q;
	logic [1:0]      level_q;
	logic [1:0]      step_q;
	logic [EW-1:0]   digit_q [3];
	logic [3:0]      slot_q;
	logic [BW-1:0]   cur_q;
	logic [EW-1:0]   clr_q;
	logic [BW-1:0]   direct_q [ibmw_pkg::DIRECT_SLOTS];
	logic [BW-1:0]   root_q [3];
	logic [ibmw_pkg::IMAGE_BLOCKS-1:0] zeroed_q;

	logic [15:0]     rel1, rel2, rel3;
	logic [BW-1:0]   ptr;
	logic [BW-1:0]   entry_v;
	logic [EW-1:0]   digit;

	assign busy  = state_q != S_IDLE;
	assign rel1  = idx_q - Ds;
	assign rel2  = rel1 - E1;
	assign rel3  = rel2 - E2;
	assign ptr   = (level_q == 2'd0) ? direct_q[slot_q] : root_q[level_q - 2'd1];
	assign digit = digit_q[step_q];
	assign entry_v = zeroed_q[cur_q] ? ram_rdata : '0;
	assign ram_raddr = {cur_q, digit};

	always_comb begin
		take      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = {cur_q, digit};
		ram_wdata = stat.blk;
		unique case (state_q)
			S_PTR: begin
				take = (ptr == '0) && stat.avail;
			end
			S_CHK: begin
				take   = (entry_v == '0) && stat.avail;
				ram_we = take;
			end
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q, clr_q};
				// a reissued block that is its own parent keeps the new link
				ram_wdata = (cur_q == parent_block && clr_q == parent_entry) ? cur_q : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe   <= 1'b0;
			zeroed_q <= '0;
			for (int i = 0; i < ibmw_pkg::DIRECT_SLOTS; i++) direct_q[i] <= '0;
			for (int i = 0; i < 3; i++) root_q[i] <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q   <= file_block;
						state_q <= S_DEC;
						if (new_file) begin
							for (int i = 0; i < ibmw_pkg::DIRECT_SLOTS; i++) direct_q[i] <= '0;
							for (int i = 0; i < 3; i++) root_q[i] <= '0;
						end
					end
				end
				S_DEC: begin
					step_q  <= '0;
					slot_q  <= idx_q[3:0];
					state_q <= S_PTR;
					priority if (idx_q < Ds) begin
						level_q <= 2'd0;
					end else if (rel1 < E1) begin
						level_q    <= 2'd1;
						digit_q[0] <= rel1[EW-1:0];
					end else if (rel2 < E2) begin
						level_q    <= 2'd2;
						digit_q[0] <= rel2[2*EW-1:EW];
						digit_q[1] <= rel2[EW-1:0];
					end else if ({1'b0, rel3} < E3 && idx_q >= Ds + E1 + E2) begin
						level_q    <= 2'd3;
						digit_q[0] <= rel3[3*EW-1:2*EW];
						digit_q[1] <= rel3[2*EW-1:EW];
						digit_q[2] <= rel3[EW-1:0];
					end else begin
						strobe         <= 1'b1;
						kind           <= ibmw_pkg::KIND_ERROR;
						block_number   <= '0;
						in_pointer_set <= 1'b0;
						pointer_slot   <= '0;
						parent_block   <= '0;
						parent_entry   <= '0;
						last           <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_PTR: begin
					strobe         <= 1'b1;
					in_pointer_set <= 1'b0;
					pointer_slot   <= '0;
					parent_block   <= '0;
					parent_entry   <= '0;
					if (ptr != '0) begin
						cur_q <= ptr;
						if (level_q == 2'd0) begin
							kind         <= ibmw_pkg::KIND_FINAL;
							block_number <= ptr;
							last         <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							strobe  <= 1'b0;
							state_q <= S_RD;
						end
					end else if (!stat.avail) begin
						kind         <= ibmw_pkg::KIND_ERROR;
						block_number <= '0;
						last         <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						kind           <= ibmw_pkg::KIND_ALLOC;
						block_number   <= stat.blk;
						in_pointer_set <= 1'b1;
						last           <= 1'b0;
						cur_q          <= stat.blk;
						clr_q          <= '0;
						zeroed_q[stat.blk] <= 1'b1;
						state_q        <= S_CLR;
						if (level_q == 2'd0) begin
							pointer_slot     <= slot_q;
							direct_q[slot_q] <= stat.blk;
						end else begin
							pointer_slot            <= Ds[3:0] + {2'b00, level_q} - 4'd1;
							root_q[level_q - 2'd1] <= stat.blk;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == EW'(ibmw_pkg::ENTRIES_PER_INDEX - 1)) begin
						if (step_q == level_q) begin
							strobe         <= 1'b1;
							kind           <= ibmw_pkg::KIND_FINAL;
							block_number   <= cur_q;
							in_pointer_set <= 1'b0;
							pointer_slot   <= '0;
							parent_block   <= '0;
							parent_entry   <= '0;
							last           <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					in_pointer_set <= 1'b0;
					pointer_slot   <= '0;
					parent_block   <= '0;
					parent_entry   <= '0;
					step_q         <= step_q + 1'b1;
					if (entry_v != '0) begin
						cur_q <= entry_v;
						if (step_q + 2'd1 == level_q) begin
							strobe       <= 1'b1;
							kind         <= ibmw_pkg::KIND_FINAL;
							block_number <= entry_v;
							last         <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end else if (!stat.avail) begin
						strobe       <= 1'b1;
						kind         <= ibmw_pkg::KIND_ERROR;
						block_number <= '0;
						last         <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						strobe       <= 1'b1;
						kind         <= ibmw_pkg::KIND_ALLOC;
						block_number <= stat.blk;
						parent_block <= cur_q;
						parent_entry <= digit;
						last         <= 1'b0;
						cur_q        <= stat.blk;
						clr_q        <= '0;
						zeroed_q[stat.blk] <= 1'b1;
						state_q      <= S_CLR;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/indexed_block_map_walker_top.sv @@
// top level of the indexed block map walker
// Each transaction maps one file block to a physical block through eleven direct
// pointers and single, double and triple indirect index blocks, allocating missing
// pointers and entries from a bump counter. busy stays high for the whole walk.
// Every new block gets its 16 index entries cleared one per cycle through the
// single write port of the index store.
// Results appear one per cycle at most, each for exactly one cycle under strobe,
// with last marking the final or error result; the receiver must take them then.
module indexed_block_map_walker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] file_block,
	input  logic        new_file,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [7:0]  block_number,
	output logic        in_pointer_set,
	output logic [3:0]  pointer_slot,
	output logic [7:0]  parent_block,
	output logic [3:0]  parent_entry,
	output logic        last
);

	ibmw_pkg::alloc_stat_t              stat;
	logic                               take;
	logic                               ram_we;
	logic [ibmw_pkg::STORE_AW-1:0]      ram_waddr;
	logic [ibmw_pkg::STORE_AW-1:0]      ram_raddr;
	logic [ibmw_pkg::BLK_W-1:0]         ram_wdata;
	logic [ibmw_pkg::BLK_W-1:0]         ram_rdata;

	ibmw_alloc u_alloc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.stat      (stat)
	);

	ibmw_ram #(
		.WIDTH (ibmw_pkg::BLK_W),
		.DEPTH (ibmw_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ibmw_ctl u_ctl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.file_block     (file_block),
		.new_file       (new_file),
		.stat           (stat),
		.take           (take),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.strobe         (strobe),
		.kind           (kind),
		.block_number   (block_number),
		.in_pointer_set (in_pointer_set),
		.pointer_slot   (pointer_slot),
		.parent_block   (parent_block),
		.parent_entry   (parent_entry),
		.last           (last)
	);

endmodule
